[hw/rtl/x25519ss_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x25519ss_pkg
// Shared types, constants and the ladder step program for the X25519 unit.
// ----------------------------------------------------------------------------
package x25519ss_pkg;

    // Field prime 2^255 - 19 and the curve constant (A - 2) / 4 = 121665
    localparam logic [255:0] P_MOD     = {1'b0, {250{1'b1}}, 5'b01101};
    localparam logic [255:0] A24_CONST = 256'h1DB41;
    localparam logic [255:0] FE_ONE    = 256'h1;

    localparam logic [7:0] LADDER_TOP      = 8'd254;
    localparam logic [7:0] INV_TOP         = 8'd253;
    localparam logic [4:0] LADDER_OPS_LAST = 5'd17;
    localparam logic [1:0] LAST_WORD_IDX   = 2'd3;

    // Field unit operations
    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_FRZ = 2'd3
    } fe_op_t;

    // Field element store entries
    typedef enum logic [3:0] {
        A_X1  = 4'd0,
        A_X2  = 4'd1,
        A_Z2  = 4'd2,
        A_X3  = 4'd3,
        A_Z3  = 4'd4,
        A_A   = 4'd5,
        A_AA  = 4'd6,
        A_B   = 4'd7,
        A_BB  = 4'd8,
        A_E   = 4'd9,
        A_C   = 4'd10,
        A_D   = 4'd11,
        A_DA  = 4'd12,
        A_CB  = 4'd13,
        A_A24 = 4'd14,
        A_INV = 4'd15
    } fe_addr_t;

    // Request from the sequencer to the field unit
    typedef struct packed {
        logic   start;
        fe_op_t op;
    } fe_req_t;

    // One instruction: dst = sa op sb
    typedef struct packed {
        fe_op_t   op;
        fe_addr_t dst;
        fe_addr_t sa;
        fe_addr_t sb;
    } ucode_t;

    function automatic ucode_t uc(fe_op_t o, fe_addr_t d, fe_addr_t s1, fe_addr_t s2);
        ucode_t r;
        r.op  = o;
        r.dst = d;
        r.sa  = s1;
        r.sb  = s2;
        return r;
    endfunction

    // One ladder step in logical (unswapped) names
    function automatic ucode_t ladder_ucode(logic [4:0] idx);
        ucode_t r;
        case (idx)
            5'd0:    r = uc(OP_ADD, A_A,  A_X2,  A_Z2);
            5'd1:    r = uc(OP_MUL, A_AA, A_A,   A_A);
            5'd2:    r = uc(OP_SUB, A_B,  A_X2,  A_Z2);
            5'd3:    r = uc(OP_MUL, A_BB, A_B,   A_B);
            5'd4:    r = uc(OP_SUB, A_E,  A_AA,  A_BB);
            5'd5:    r = uc(OP_ADD, A_C,  A_X3,  A_Z3);
            5'd6:    r = uc(OP_SUB, A_D,  A_X3,  A_Z3);
            5'd7:    r = uc(OP_MUL, A_DA, A_D,   A_A);
            5'd8:    r = uc(OP_MUL, A_CB, A_C,   A_B);
            5'd9:    r = uc(OP_ADD, A_X3, A_DA,  A_CB);
            5'd10:   r = uc(OP_MUL, A_X3, A_X3,  A_X3);
            5'd11:   r = uc(OP_SUB, A_Z3, A_DA,  A_CB);
            5'd12:   r = uc(OP_MUL, A_Z3, A_Z3,  A_Z3);
            5'd13:   r = uc(OP_MUL, A_Z3, A_Z3,  A_X1);
            5'd14:   r = uc(OP_MUL, A_X2, A_AA,  A_BB);
            5'd15:   r = uc(OP_MUL, A_Z2, A_A24, A_E);
            5'd16:   r = uc(OP_ADD, A_Z2, A_Z2,  A_AA);
            5'd17:   r = uc(OP_MUL, A_Z2, A_Z2,  A_E);
            default: r = uc(OP_ADD, A_A,  A_X2,  A_Z2);
        endcase
        return r;
    endfunction

    // Conditional swap done by renaming the ladder entries
    function automatic fe_addr_t remap(fe_addr_t a, logic sw);
        fe_addr_t r;
        case (a)
            A_X2:    r = sw ? A_X3 : A_X2;
            A_X3:    r = sw ? A_X2 : A_X3;
            A_Z2:    r = sw ? A_Z3 : A_Z2;
            A_Z3:    r = sw ? A_Z2 : A_Z3;
            default: r = a;
        endcase
        return r;
    endfunction

endpackage

[hw/rtl/x25519ss_fe_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x25519ss_fe_unit
// Multi-cycle GF(2^255-19) add, subtract, multiply and final reduction.
// Values stay below 2^256; the freeze op brings one below p.
// ----------------------------------------------------------------------------
module x25519ss_fe_unit (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  x25519ss_pkg::fe_req_t   req,
    input  logic [255:0]            opa,
    input  logic [255:0]            opb,
    output logic                    done,
    output logic [255:0]            result
);
    import x25519ss_pkg::*;

    typedef enum logic [4:0] {
        U_IDLE = 5'b00001,
        U_MUL  = 5'b00010,
        U_RED  = 5'b00100,
        U_FOLD = 5'b01000,
        U_FRZ  = 5'b10000
    } ustate_t;

    ustate_t            state_reg;
    logic               done_reg;
    logic [255:0]       a_reg;
    logic [255:0]       b_reg;
    logic [67:0]        acc_reg;
    logic [3:0]         k_reg;
    logic [2:0]         i_reg;
    logic [31:0]        lo_reg [8];
    logic [31:0]        hi_reg [8];
    logic [255:0]       w_reg;
    logic signed [6:0]  c_reg;
    logic               frz_cnt_reg;

    logic [3:0]   j_idx;
    logic [31:0]  a_word;
    logic [31:0]  b_word;
    logic [63:0]  prod;
    logic [67:0]  mac;
    logic [2:0]   i_end;
    logic [3:0]   k_nxt;
    logic [3:0]   k_off;
    logic [2:0]   i_start;
    logic [39:0]  red_sum;
    logic [11:0]  c38;
    logic [256:0] fold_add;
    logic [256:0] fold_sub;
    logic [256:0] sum_ab;
    logic [256:0] dif_ab;
    logic         ge_p;

    // Product scanning: column k, term i, partner word j = k - i
    always_comb begin
        j_idx   = k_reg - {1'b0, i_reg};
        a_word  = a_reg[{i_reg, 5'b0} +: 32];
        b_word  = b_reg[{j_idx[2:0], 5'b0} +: 32];
        prod    = a_word * b_word;
        mac     = acc_reg + {4'b0, prod};
        i_end   = k_reg[3] ? 3'd7 : k_reg[2:0];
        k_nxt   = k_reg + 4'd1;
        k_off   = k_nxt - 4'd7;
        i_start = k_nxt[3] ? k_off[2:0] : 3'd0;
    end

    // Reduction: 2^256 = 38 mod p
    always_comb begin
        red_sum  = 40'(lo_reg[i_reg]) + 40'(hi_reg[i_reg]) * 40'd38 + 40'(acc_reg[7:0]);
        c38      = 12'(c_reg[5:0]) * 12'd38;
        fold_add = {1'b0, w_reg} + {245'b0, c38};
        fold_sub = {1'b0, w_reg} - 257'd38;
        sum_ab   = {1'b0, opa} + {1'b0, opb};
        dif_ab   = {1'b0, opa} - {1'b0, opb};
        ge_p     = (w_reg >= P_MOD);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= U_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                U_IDLE: begin
                    if (req.start) begin
                        case (req.op)
                            OP_MUL: begin
                                a_reg     <= opa;
                                b_reg     <= opb;
                                acc_reg   <= '0;
                                k_reg     <= '0;
                                i_reg     <= '0;
                                state_reg <= U_MUL;
                            end
                            OP_ADD: begin
                                w_reg     <= sum_ab[255:0];
                                c_reg     <= {6'b0, sum_ab[256]};
                                state_reg <= U_FOLD;
                            end
                            OP_SUB: begin
                                w_reg     <= dif_ab[255:0];
                                c_reg     <= dif_ab[256] ? 7'h7F : 7'h00;
                                state_reg <= U_FOLD;
                            end
                            OP_FRZ: begin
                                w_reg       <= opa;
                                frz_cnt_reg <= 1'b0;
                                state_reg   <= U_FRZ;
                            end
                            default: state_reg <= U_IDLE;
                        endcase
                    end
                end
                U_MUL: begin
                    if (i_reg == i_end) begin
                        if (k_reg[3]) begin
                            hi_reg[k_reg[2:0]] <= mac[31:0];
                        end else begin
                            lo_reg[k_reg[2:0]] <= mac[31:0];
                        end
                        // last column also carries the top product word
                        if (k_reg == 4'd14) begin
                            hi_reg[7] <= mac[63:32];
                            acc_reg   <= '0;
                            i_reg     <= '0;
                            state_reg <= U_RED;
                        end else begin
                            acc_reg <= 68'(mac[67:32]);
                            k_reg   <= k_nxt;
                            i_reg   <= i_start;
                        end
                    end else begin
                        acc_reg <= mac;
                        i_reg   <= i_reg + 3'd1;
                    end
                end
                U_RED: begin
                    w_reg[{i_reg, 5'b0} +: 32] <= red_sum[31:0];
                    acc_reg <= 68'(red_sum[39:32]);
                    if (i_reg == 3'd7) begin
                        c_reg     <= {1'b0, red_sum[37:32]};
                        state_reg <= U_FOLD;
                    end else begin
                        i_reg <= i_reg + 3'd1;
                    end
                end
                U_FOLD: begin
                    // fold the overflow back in until none is left
                    if (c_reg == 7'sd0) begin
                        done_reg  <= 1'b1;
                        state_reg <= U_IDLE;
                    end else if (c_reg[6]) begin
                        w_reg <= fold_sub[255:0];
                        c_reg <= fold_sub[256] ? 7'h7F : 7'h00;
                    end else begin
                        w_reg <= fold_add[255:0];
                        c_reg <= {6'b0, fold_add[256]};
                    end
                end
                U_FRZ: begin
                    // a value below 2^256 needs at most two subtractions
                    if (ge_p) begin
                        w_reg <= w_reg - P_MOD;
                    end
                    frz_cnt_reg <= 1'b1;
                    if (frz_cnt_reg) begin
                        done_reg  <= 1'b1;
                        state_reg <= U_IDLE;
                    end
                end
                default: state_reg <= U_IDLE;
            endcase
        end
    end

    assign done   = done_reg;
    assign result = w_reg;

endmodule

[hw/rtl/x25519_shared_secret_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x25519_shared_secret_unit
// X25519 Montgomery ladder with Fermat inversion over a field element store.
// ----------------------------------------------------------------------------
// Load the scalar and peer u-coordinate as four word pairs at the index each
// names; the item with index 3 starts the computation and the block takes no
// further item until the four result words (index 0 first, last_word on the
// fourth) have been delivered. Words 0 to 2 are taken in one cycle each. An
// index-3 item runs 255 ladder steps of 18 field operations plus 506
// multiplications for the inversion and one for the final product, all run
// one at a time through a single 32x32 multiply-accumulate unit with operands
// read from a 16-entry field element memory.
// ----------------------------------------------------------------------------
module x25519_shared_secret_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_word_index,
    input  logic [63:0] s_scalar_word,
    input  logic [63:0] s_peer_word,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_secret_word,
    output logic [1:0]  m_secret_index,
    output logic        m_last_word
);
    import x25519ss_pkg::*;

    typedef enum logic [5:0] {
        S_LOAD = 6'b000001,
        S_INIT = 6'b000010,
        S_RD   = 6'b000100,
        S_WAIT = 6'b001000,
        S_EXEC = 6'b010000,
        S_OUT  = 6'b100000
    } state_t;

    typedef enum logic [4:0] {
        PH_LADDER = 5'b00001,
        PH_INVSQ  = 5'b00010,
        PH_INVMUL = 5'b00100,
        PH_FINAL  = 5'b01000,
        PH_FREEZE = 5'b10000
    } phase_t;

    state_t            state_reg;
    phase_t            phase_reg;
    logic [3:0][63:0]  scalar_reg;
    logic [3:0][63:0]  peer_reg;
    logic [2:0]        init_cnt_reg;
    logic [7:0]        t_reg;
    logic [4:0]        op_idx_reg;
    logic              first_reg;
    logic [1:0]        out_idx_reg;
    logic [255:0]      res_reg;

    // field element store
    logic [255:0] fe_mem [16];
    logic [255:0] rd_a_reg;
    logic [255:0] rd_b_reg;

    logic [255:0] scalar_flat;
    logic [255:0] u_masked;
    logic         sbit;
    ucode_t       lad;
    ucode_t       cur;
    logic         we;
    fe_addr_t     waddr;
    logic [255:0] wdata;
    fe_req_t      req;
    logic         fe_done;
    logic [255:0] fe_result;

    // clamped scalar bit and masked u
    always_comb begin
        scalar_flat = scalar_reg;
        u_masked    = {1'b0, peer_reg[3][62:0], peer_reg[2], peer_reg[1], peer_reg[0]};
        if (t_reg == LADDER_TOP) begin
            sbit = 1'b1;
        end else if (t_reg < 8'd3) begin
            sbit = 1'b0;
        end else begin
            sbit = scalar_flat[t_reg];
        end
    end

    // current instruction
    always_comb begin
        lad = ladder_ucode(op_idx_reg);
        case (phase_reg)
            PH_LADDER: cur = uc(lad.op, remap(lad.dst, sbit), remap(lad.sa, sbit),
                                remap(lad.sb, sbit));
            PH_INVSQ:  cur = first_reg ? uc(OP_MUL, A_INV, A_Z2, A_Z2)
                                       : uc(OP_MUL, A_INV, A_INV, A_INV);
            PH_INVMUL: cur = uc(OP_MUL, A_INV, A_INV, A_Z2);
            PH_FINAL:  cur = uc(OP_MUL, A_INV, A_X2, A_INV);
            PH_FREEZE: cur = uc(OP_FRZ, A_INV, A_INV, A_INV);
            default:   cur = uc(OP_FRZ, A_INV, A_INV, A_INV);
        endcase
    end

    // store write port: ladder start values, then unit results
    always_comb begin
        we    = 1'b0;
        waddr = cur.dst;
        wdata = fe_result;
        if (state_reg == S_INIT) begin
            we = 1'b1;
            case (init_cnt_reg)
                3'd0:    begin waddr = A_X1;  wdata = u_masked;  end
                3'd1:    begin waddr = A_X2;  wdata = FE_ONE;    end
                3'd2:    begin waddr = A_Z2;  wdata = '0;        end
                3'd3:    begin waddr = A_X3;  wdata = u_masked;  end
                3'd4:    begin waddr = A_Z3;  wdata = FE_ONE;    end
                default: begin waddr = A_A24; wdata = A24_CONST; end
            endcase
        end else if (state_reg == S_EXEC && fe_done && phase_reg != PH_FREEZE) begin
            we = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            fe_mem[waddr] <= wdata;
        end
        rd_a_reg <= fe_mem[cur.sa];
        rd_b_reg <= fe_mem[cur.sb];
    end

    assign req.start = (state_reg == S_WAIT);
    assign req.op    = cur.op;

    x25519ss_fe_unit u_fe (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .opa     (rd_a_reg),
        .opb     (rd_b_reg),
        .done    (fe_done),
        .result  (fe_result)
    );

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_LOAD;
            phase_reg   <= PH_LADDER;
            out_idx_reg <= '0;
        end else begin
            case (state_reg)
                S_LOAD: begin
                    if (s_valid) begin
                        scalar_reg[s_word_index] <= s_scalar_word;
                        peer_reg[s_word_index]   <= s_peer_word;
                        if (s_word_index == LAST_WORD_IDX) begin
                            init_cnt_reg <= '0;
                            state_reg    <= S_INIT;
                        end
                    end
                end
                S_INIT: begin
                    if (init_cnt_reg == 3'd5) begin
                        phase_reg  <= PH_LADDER;
                        t_reg      <= LADDER_TOP;
                        op_idx_reg <= '0;
                        state_reg  <= S_RD;
                    end else begin
                        init_cnt_reg <= init_cnt_reg + 3'd1;
                    end
                end
                S_RD:   state_reg <= S_WAIT;
                S_WAIT: state_reg <= S_EXEC;
                S_EXEC: begin
                    if (fe_done) begin
                        state_reg <= S_RD;
                        case (phase_reg)
                            PH_LADDER: begin
                                if (op_idx_reg == LADDER_OPS_LAST) begin
                                    op_idx_reg <= '0;
                                    if (t_reg == 8'd0) begin
                                        phase_reg <= PH_INVSQ;
                                        t_reg     <= INV_TOP;
                                        first_reg <= 1'b1;
                                    end else begin
                                        t_reg <= t_reg - 8'd1;
                                    end
                                end else begin
                                    op_idx_reg <= op_idx_reg + 5'd1;
                                end
                            end
                            PH_INVSQ: begin
                                first_reg <= 1'b0;
                                // exponent bits 2 and 4 of p-2 are zero
                                if (t_reg == 8'd2 || t_reg == 8'd4) begin
                                    t_reg <= t_reg - 8'd1;
                                end else begin
                                    phase_reg <= PH_INVMUL;
                                end
                            end
                            PH_INVMUL: begin
                                if (t_reg == 8'd0) begin
                                    phase_reg <= PH_FINAL;
                                end else begin
                                    t_reg     <= t_reg - 8'd1;
                                    phase_reg <= PH_INVSQ;
                                end
                            end
                            PH_FINAL: phase_reg <= PH_FREEZE;
                            PH_FREEZE: begin
                                res_reg     <= fe_result;
                                out_idx_reg <= '0;
                                state_reg   <= S_OUT;
                            end
                            default: phase_reg <= PH_LADDER;
                        endcase
                    end
                end
                S_OUT: begin
                    if (m_ready) begin
                        out_idx_reg <= out_idx_reg + 2'd1;
                        if (out_idx_reg == LAST_WORD_IDX) begin
                            state_reg <= S_LOAD;
                        end
                    end
                end
                default: state_reg <= S_LOAD;
            endcase
        end
    end

    assign s_ready        = (state_reg == S_LOAD);
    assign m_valid        = (state_reg == S_OUT);
    assign m_secret_word  = res_reg[{out_idx_reg, 6'b0} +: 64];
    assign m_secret_index = out_idx_reg;
    assign m_last_word    = (out_idx_reg == LAST_WORD_IDX);

endmodule
